### hdl/jsv_pkg.sv
package jsv_pkg;

    localparam int MAX_DEPTH_DEF = 64;
    localparam int DL_W = 7;
    localparam logic [DL_W-1:0] DEPTH_LIMIT_RST = 7'd64;

    typedef enum logic [4:0] {
        S_TOP       = 5'd0,
        S_OBJ_FIRST = 5'd1,
        S_OBJ_NAME  = 5'd2,
        S_NAME      = 5'd3,
        S_NAME_ESC  = 5'd4,
        S_NAME_HEX  = 5'd5,
        S_COLON     = 5'd6,
        S_VALUE     = 5'd7,
        S_ARR_FIRST = 5'd8,
        S_AFTER     = 5'd9,
        S_STR       = 5'd10,
        S_STR_ESC   = 5'd11,
        S_STR_HEX   = 5'd12,
        S_LIT_N     = 5'd13,
        S_LIT_T     = 5'd14,
        S_LIT_F     = 5'd15,
        S_N_SIGN    = 5'd16,
        S_N_ZERO    = 5'd17,
        S_N_INT     = 5'd18,
        S_N_DOT     = 5'd19,
        S_N_FRAC    = 5'd20,
        S_N_EXP     = 5'd21,
        S_N_EXPS    = 5'd22,
        S_N_EXPD    = 5'd23
    } t_state;

    typedef enum logic [3:0] {
        E_NONE    = 4'd0,
        E_TOP     = 4'd1,
        E_NAME    = 4'd2,
        E_COLON   = 4'd3,
        E_VALUE   = 4'd4,
        E_COMMA   = 4'd5,
        E_ESCAPE  = 4'd6,
        E_STRING  = 4'd7,
        E_LITERAL = 4'd8,
        E_NUMBER  = 4'd9,
        E_UNCLOSED = 4'd10,
        E_DEEP    = 4'd11
    } t_err;

    typedef struct packed {
        logic       doc_valid;
        logic [3:0] error_kind;
        logic [31:0] error_offset;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // expected literal character at a given progress
    function automatic logic [7:0] lit_char(input t_state s, input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        case (s)
            S_LIT_N: case (p)
                3'd1: r = 8'h75;
                3'd2: r = 8'h6c;
                3'd3: r = 8'h6c;
                default: r = 8'h00;
            endcase
            S_LIT_T: case (p)
                3'd1: r = 8'h72;
                3'd2: r = 8'h75;
                3'd3: r = 8'h65;
                default: r = 8'h00;
            endcase
            default: case (p)
                3'd1: r = 8'h61;
                3'd2: r = 8'h6c;
                3'd3: r = 8'h73;
                3'd4: r = 8'h65;
                default: r = 8'h00;
            endcase
        endcase
        return r;
    endfunction

endpackage

### hdl/jsv_if.sv
interface jsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_doc;
    modport source (output valid, output text_byte, output end_of_doc, input ready);
    modport sink (input valid, input text_byte, input end_of_doc, output ready);
endinterface

interface jsv_out_if;
    logic        valid;
    logic        ready;
    logic        doc_valid;
    logic [3:0]  error_kind;
    logic [31:0] error_offset;
    modport source (output valid, output doc_valid, output error_kind, output error_offset,
                    input ready);
    modport sink (input valid, input doc_valid, input error_kind, input error_offset,
                  output ready);
endinterface

### hdl/json_syntax_validator_top.sv
// Streaming JSON syntax checker. One byte is taken per clock unless the input
// is held off; the push-down state update for each byte is combinational, so
// the block runs at one byte per cycle. The byte marked end_of_doc yields one
// result (valid flag, first error kind, its byte offset) in the result register
// as that byte is taken, and clears the document state; depth_limit persists. A
// result waiting in the result register holds off the input only while the
// result side is not ready. The nesting stack is a memory of MAX_DEPTH one-bit
// entries; the top entry is kept in a register, refreshed by a registered read
// of the entry that becomes the top when a container closes.
module json_syntax_validator_top #(
    parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    jsv_in_if.sink                   in_w,
    jsv_out_if.source                out_w,
    input  logic                     i_cfg_we,
    input  logic [jsv_pkg::DL_W-1:0] i_cfg_wdata
);
    import jsv_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [DL_W-1:0]      r_limit;
    logic                 r_stack [MAX_DEPTH];
    logic                 r_top;
    logic [DW-1:0]        r_depth, n_depth;
    t_state               r_state, n_state;
    logic [2:0]           r_lit, n_lit;
    logic [2:0]           r_hex, n_hex;
    t_err                 r_err, n_err;
    logic [31:0]          r_pos, n_pos_ctr;
    logic [31:0]          r_epos, n_epos;
    logic                 r_ovalid;
    t_result              r_res, n_res;

    logic accept;
    logic [7:0] c;
    logic last;
    logic top_obj;
    logic push_en;
    logic push_obj;
    logic [DW-1:0] rd_full;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] lim;
    logic [DW+DL_W:0] lim_ext;

    assign in_w.ready  = !r_ovalid || out_w.ready;
    assign accept      = in_w.valid && in_w.ready;
    assign c           = in_w.text_byte;
    assign last        = in_w.end_of_doc;
    assign out_w.valid = r_ovalid;
    assign out_w.doc_valid    = r_res.doc_valid;
    assign out_w.error_kind   = r_res.error_kind;
    assign out_w.error_offset = r_res.error_offset;

    always_comb begin
        if ({{(DW+1){1'b0}}, r_limit} < (DW+DL_W+1)'(MAX_DEPTH))
            lim_ext = {{(DW+1){1'b0}}, r_limit};
        else
            lim_ext = (DW+DL_W+1)'(MAX_DEPTH);
    end
    assign lim = lim_ext[DW-1:0];

    assign top_obj = (r_depth != '0) && r_top;
    assign rd_full = n_depth - DW'(1);
    assign rd_addr = rd_full[AW-1:0];

    always_comb begin
        t_err   fl;
        t_state s;
        logic [DW-1:0] dd;
        t_err fk;
        t_err ee;
        logic [31:0] eo;
        logic do_after, do_open, open_obj, do_vstart;
        n_depth = r_depth;
        n_state = r_state;
        n_lit   = r_lit;
        n_hex   = r_hex;
        push_en  = 1'b0;
        push_obj = 1'b0;
        dd = '0;
        fl = E_NONE;
        do_after = 1'b0;
        do_open = 1'b0;
        open_obj = 1'b0;
        do_vstart = 1'b0;
        s = r_state;
        unique case (s)
            S_TOP: begin
                if (!is_blank(c)) begin
                    if (c == 8'h7b) begin do_open = 1'b1; open_obj = 1'b1; end
                    else if (c == 8'h5b) do_open = 1'b1;
                    else fl = E_TOP;
                end
            end
            S_OBJ_FIRST: begin
                if (!is_blank(c)) begin
                    if (c == 8'h7d) begin
                        dd = r_depth - DW'(1);
                        n_depth = dd;
                        n_state = (dd == '0) ? S_TOP : S_AFTER;
                    end else if (c == 8'h22) n_state = S_NAME;
                    else fl = E_NAME;
                end
            end
            S_OBJ_NAME: begin
                if (!is_blank(c)) begin
                    if (c == 8'h22) n_state = S_NAME;
                    else fl = E_NAME;
                end
            end
            S_NAME, S_STR: begin
                if (c == 8'h5c) n_state = (s == S_NAME) ? S_NAME_ESC : S_STR_ESC;
                else if (c == 8'h22) n_state = (s == S_NAME) ? S_COLON : S_AFTER;
            end
            S_NAME_ESC, S_STR_ESC: begin
                case (c)
                    8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74:
                        n_state = (s == S_NAME_ESC) ? S_NAME : S_STR;
                    8'h75: begin
                        n_hex = 3'd4;
                        n_state = (s == S_NAME_ESC) ? S_NAME_HEX : S_STR_HEX;
                    end
                    default: fl = E_ESCAPE;
                endcase
            end
            S_NAME_HEX, S_STR_HEX: begin
                if (!is_hex(c)) fl = E_ESCAPE;
                else begin
                    n_hex = (r_hex != 3'd0) ? r_hex - 3'd1 : 3'd0;
                    if (n_hex == 3'd0) n_state = (s == S_NAME_HEX) ? S_NAME : S_STR;
                end
            end
            S_COLON: begin
                if (!is_blank(c)) begin
                    if (c == 8'h3a) n_state = S_VALUE;
                    else fl = E_COLON;
                end
            end
            S_VALUE: do_vstart = 1'b1;
            S_ARR_FIRST: begin
                if (c == 8'h5d) begin
                    dd = r_depth - DW'(1);
                    n_depth = dd;
                    n_state = (dd == '0) ? S_TOP : S_AFTER;
                end else do_vstart = 1'b1;
            end
            S_AFTER: do_after = 1'b1;
            S_LIT_N, S_LIT_T, S_LIT_F: begin
                if (r_lit != 3'd0 && r_lit <= ((s == S_LIT_F) ? 3'd4 : 3'd3)
                    && c == lit_char(s, r_lit)) begin
                    if (r_lit == ((s == S_LIT_F) ? 3'd4 : 3'd3)) begin
                        n_lit = 3'd0;
                        n_state = S_AFTER;
                    end else n_lit = r_lit + 3'd1;
                end else fl = E_LITERAL;
            end
            S_N_SIGN: begin
                if (c == 8'h30) n_state = S_N_ZERO;
                else if (is_digit(c)) n_state = S_N_INT;
                else fl = E_NUMBER;
            end
            S_N_ZERO, S_N_INT: begin
                if (is_digit(c)) begin
                    if (s == S_N_ZERO) fl = E_NUMBER;
                end else if (c == 8'h2e) n_state = S_N_DOT;
                else if (c == 8'h65 || c == 8'h45) n_state = S_N_EXP;
                else do_after = 1'b1;
            end
            S_N_DOT: begin
                if (is_digit(c)) n_state = S_N_FRAC;
                else fl = E_NUMBER;
            end
            S_N_FRAC: begin
                if (!is_digit(c)) begin
                    if (c == 8'h65 || c == 8'h45) n_state = S_N_EXP;
                    else do_after = 1'b1;
                end
            end
            S_N_EXP: begin
                if (c == 8'h2b || c == 8'h2d) n_state = S_N_EXPS;
                else if (is_digit(c)) n_state = S_N_EXPD;
                else fl = E_NUMBER;
            end
            S_N_EXPS: begin
                if (is_digit(c)) n_state = S_N_EXPD;
                else fl = E_NUMBER;
            end
            S_N_EXPD: if (!is_digit(c)) do_after = 1'b1;
            default: n_state = S_TOP;
        endcase

        if (do_vstart && !is_blank(c)) begin
            n_lit = 3'd0;
            case (c)
                8'h7b: begin do_open = 1'b1; open_obj = 1'b1; end
                8'h5b: do_open = 1'b1;
                8'h22: n_state = S_STR;
                8'h6e: begin n_state = S_LIT_N; n_lit = 3'd1; end
                8'h74: begin n_state = S_LIT_T; n_lit = 3'd1; end
                8'h66: begin n_state = S_LIT_F; n_lit = 3'd1; end
                8'h2d: n_state = S_N_SIGN;
                8'h30: n_state = S_N_ZERO;
                default: begin
                    if (c >= 8'h31 && c <= 8'h39) n_state = S_N_INT;
                    else fl = E_VALUE;
                end
            endcase
        end

        if (do_open) begin
            if (r_depth >= lim) fl = E_DEEP;
            else begin
                push_en  = 1'b1;
                push_obj = open_obj;
                n_depth = r_depth + DW'(1);
                n_state = open_obj ? S_OBJ_FIRST : S_ARR_FIRST;
            end
        end

        if (do_after) begin
            n_state = S_AFTER;
            if (!is_blank(c)) begin
                if (c == 8'h2c) n_state = top_obj ? S_OBJ_NAME : S_VALUE;
                else if ((c == 8'h7d && top_obj) || (c == 8'h5d && !top_obj)) begin
                    dd = (r_depth != '0) ? r_depth - DW'(1) : '0;
                    n_depth = dd;
                    n_state = (dd == '0) ? S_TOP : S_AFTER;
                end else fl = E_COMMA;
            end
        end

        if (r_err != E_NONE) begin
            n_depth = r_depth;
            n_state = r_state;
            n_lit   = r_lit;
            n_hex   = r_hex;
            push_en = 1'b0;
            fl      = E_NONE;
        end

        n_pos_ctr = (r_pos != 32'hffff_ffff) ? r_pos + 32'd1 : r_pos;
        n_err  = r_err;
        n_epos = r_epos;
        if (r_err == E_NONE && fl != E_NONE) begin
            n_err  = fl;
            n_epos = r_pos;
        end

        // error raised when the document ends inside a construct
        fk = E_UNCLOSED;
        if ((n_state >= S_NAME && n_state <= S_NAME_HEX)
            || (n_state >= S_STR && n_state <= S_STR_HEX)) fk = E_STRING;
        else if (n_state >= S_LIT_N && n_state <= S_LIT_F) fk = E_LITERAL;
        else if (n_state == S_N_SIGN || n_state == S_N_DOT || n_state == S_N_EXP
                 || n_state == S_N_EXPS) fk = E_NUMBER;
        ee = n_err;
        eo = n_epos;
        if (n_err == E_NONE && n_state != S_TOP) begin
            ee = fk;
            eo = n_pos_ctr;
        end
        n_res.doc_valid    = (ee == E_NONE);
        n_res.error_kind   = ee;
        n_res.error_offset = (ee == E_NONE) ? 32'd0 : eo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= DEPTH_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_state  <= S_TOP;
            r_lit    <= 3'd0;
            r_hex    <= 3'd0;
            r_err    <= E_NONE;
            r_pos    <= 32'd0;
            r_epos   <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept && last) r_ovalid <= 1'b1;
            else if (out_w.ready) r_ovalid <= 1'b0;
            if (accept) begin
                if (last) begin
                    r_depth  <= '0;
                    r_state  <= S_TOP;
                    r_lit    <= 3'd0;
                    r_hex    <= 3'd0;
                    r_err    <= E_NONE;
                    r_pos    <= 32'd0;
                    r_epos   <= 32'd0;
                end else begin
                    r_depth <= n_depth;
                    r_state <= n_state;
                    r_lit   <= n_lit;
                    r_hex   <= n_hex;
                    r_err   <= n_err;
                    r_pos   <= n_pos_ctr;
                    r_epos  <= n_epos;
                end
            end
        end
    end

    // stack memory, top entry cached with a registered read
    always_ff @(posedge i_clk) begin
        if (accept && push_en) r_stack[r_depth[AW-1:0]] <= push_obj;
        if (accept) r_top <= push_en ? push_obj : r_stack[rd_addr];
        if (accept && last) r_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (out_w.valid && r_depth == '0 && r_err == E_NONE))
        else $error("result not raised or state not cleared at end of document");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= lim_ext[DW-1:0] || r_depth <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_w.valid && out_w.doc_valid) |-> (out_w.error_kind == E_NONE))
        else $error("valid document carries an error code");

endmodule

### tb/json_syntax_validator_top_tb.sv
module json_syntax_validator_top_tb;
    import jsv_pkg::*;

    typedef logic [7:0] bytes_t[$];

    typedef struct {
        string text;
        bit    typed;
        t_err  kind;
        int    offset;
    } doc_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [DL_W-1:0] i_cfg_wdata;

    jsv_in_if in_w();
    jsv_out_if out_w();

    json_syntax_validator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_w        (in_w),
        .out_w       (out_w),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the checker state
    logic [63:0] nest_marks;
    int          nest_lvl;
    t_state      parse_st;
    int          lit_pos;
    int          hex_left;
    t_err        err_first;
    logic [31:0] byte_cnt;
    logic [31:0] err_pos;
    int          limit_reg;

    t_result doc_verdicts[$];
    int      mismatches;
    bit      tx_idle_on;
    bit      rx_idle_on;
    bit      rx_hold_req;
    int      quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit blank_ch(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_ch(logic [7:0] c);
        return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void note_err(t_err k);
        if (err_first == E_NONE) begin
            err_first = k;
            err_pos = byte_cnt;
        end
    endfunction

    function automatic void clear_doc();
        nest_marks = '0;
        nest_lvl = 0;
        parse_st = S_TOP;
        lit_pos = 0;
        hex_left = 0;
        err_first = E_NONE;
        byte_cnt = '0;
        err_pos = '0;
    endfunction

    function automatic void open_nest(bit is_obj);
        int lim;
        lim = limit_reg < 64 ? limit_reg : 64;
        if (nest_lvl >= lim) begin
            note_err(E_DEEP);
            return;
        end
        nest_marks[nest_lvl] = is_obj;
        nest_lvl++;
        parse_st = is_obj ? S_OBJ_FIRST : S_ARR_FIRST;
    endfunction

    function automatic void close_nest();
        if (nest_lvl > 0) nest_lvl--;
        parse_st = nest_lvl == 0 ? S_TOP : S_AFTER;
    endfunction

    function automatic bit in_object();
        return nest_lvl > 0 && nest_marks[nest_lvl-1];
    endfunction

    function automatic void begin_value(logic [7:0] c);
        if (blank_ch(c)) return;
        lit_pos = 1;
        case (c)
            "{": open_nest(1'b1);
            "[": open_nest(1'b0);
            "\"": parse_st = S_STR;
            "n": parse_st = S_LIT_N;
            "t": parse_st = S_LIT_T;
            "f": parse_st = S_LIT_F;
            "-": parse_st = S_N_SIGN;
            "0": parse_st = S_N_ZERO;
            default: begin
                if (c >= "1" && c <= "9") parse_st = S_N_INT;
                else note_err(E_VALUE);
            end
        endcase
        if (!(parse_st inside {S_LIT_N, S_LIT_T, S_LIT_F})) lit_pos = 0;
    endfunction

    function automatic void follow_value(logic [7:0] c);
        bit obj;
        obj = in_object();
        parse_st = S_AFTER;
        if (blank_ch(c)) return;
        if (c == ",") parse_st = obj ? S_OBJ_NAME : S_VALUE;
        else if ((c == "}" && obj) || (c == "]" && !obj)) close_nest();
        else note_err(E_COMMA);
    endfunction

    function automatic void keyword_byte(logic [7:0] c, string word);
        if (lit_pos < word.len() && c == word[lit_pos]) begin
            lit_pos++;
            if (lit_pos == word.len()) begin
                lit_pos = 0;
                parse_st = S_AFTER;
            end
        end else begin
            note_err(E_LITERAL);
        end
    endfunction

    function automatic void text_byte_in(logic [7:0] c, t_state esc_st, t_state done_st);
        if (c == 8'h5c) parse_st = esc_st;
        else if (c == "\"") parse_st = done_st;
    endfunction

    function automatic void escape_in(logic [7:0] c, t_state str_st, t_state hex_st);
        if (c inside {"\"", 8'h5c, "/", "b", "f", "n", "r", "t"}) begin
            parse_st = str_st;
        end else if (c == "u") begin
            hex_left = 4;
            parse_st = hex_st;
        end else begin
            note_err(E_ESCAPE);
        end
    endfunction

    function automatic void hex_in(logic [7:0] c, t_state str_st);
        if (!hex_ch(c)) begin
            note_err(E_ESCAPE);
            return;
        end
        if (hex_left > 0) hex_left--;
        if (hex_left == 0) parse_st = str_st;
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        case (parse_st)
            S_TOP: begin
                if (!blank_ch(c)) begin
                    if (c == "{") open_nest(1'b1);
                    else if (c == "[") open_nest(1'b0);
                    else note_err(E_TOP);
                end
            end
            S_OBJ_FIRST: begin
                if (!blank_ch(c)) begin
                    if (c == "}") close_nest();
                    else if (c == "\"") parse_st = S_NAME;
                    else note_err(E_NAME);
                end
            end
            S_OBJ_NAME: begin
                if (!blank_ch(c)) begin
                    if (c == "\"") parse_st = S_NAME;
                    else note_err(E_NAME);
                end
            end
            S_NAME: text_byte_in(c, S_NAME_ESC, S_COLON);
            S_NAME_ESC: escape_in(c, S_NAME, S_NAME_HEX);
            S_NAME_HEX: hex_in(c, S_NAME);
            S_COLON: begin
                if (!blank_ch(c)) begin
                    if (c == ":") parse_st = S_VALUE;
                    else note_err(E_COLON);
                end
            end
            S_VALUE: begin_value(c);
            S_ARR_FIRST: begin
                if (c == "]") close_nest();
                else begin_value(c);
            end
            S_AFTER: follow_value(c);
            S_STR: text_byte_in(c, S_STR_ESC, S_AFTER);
            S_STR_ESC: escape_in(c, S_STR, S_STR_HEX);
            S_STR_HEX: hex_in(c, S_STR);
            S_LIT_N: keyword_byte(c, "null");
            S_LIT_T: keyword_byte(c, "true");
            S_LIT_F: keyword_byte(c, "false");
            S_N_SIGN: begin
                if (c == "0") parse_st = S_N_ZERO;
                else if (digit_ch(c)) parse_st = S_N_INT;
                else note_err(E_NUMBER);
            end
            S_N_ZERO, S_N_INT: begin
                if (digit_ch(c)) begin
                    if (parse_st == S_N_ZERO) note_err(E_NUMBER);
                end else if (c == ".") parse_st = S_N_DOT;
                else if (c == "e" || c == "E") parse_st = S_N_EXP;
                else follow_value(c);
            end
            S_N_DOT: begin
                if (digit_ch(c)) parse_st = S_N_FRAC;
                else note_err(E_NUMBER);
            end
            S_N_FRAC: begin
                if (!digit_ch(c)) begin
                    if (c == "e" || c == "E") parse_st = S_N_EXP;
                    else follow_value(c);
                end
            end
            S_N_EXP: begin
                if (c == "+" || c == "-") parse_st = S_N_EXPS;
                else if (digit_ch(c)) parse_st = S_N_EXPD;
                else note_err(E_NUMBER);
            end
            S_N_EXPS: begin
                if (digit_ch(c)) parse_st = S_N_EXPD;
                else note_err(E_NUMBER);
            end
            S_N_EXPD: if (!digit_ch(c)) follow_value(c);
            default: parse_st = S_TOP;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] c, logic last);
        t_result r;
        if (err_first == E_NONE) parse_byte(c);
        if (byte_cnt != 32'hffff_ffff) byte_cnt++;
        if (!last) return;
        if (err_first == E_NONE && parse_st != S_TOP) begin
            if (parse_st inside {[S_NAME:S_NAME_HEX], [S_STR:S_STR_HEX]}) note_err(E_STRING);
            else if (parse_st inside {[S_LIT_N:S_LIT_F]}) note_err(E_LITERAL);
            else if (parse_st inside {S_N_SIGN, S_N_DOT, S_N_EXP, S_N_EXPS})
                note_err(E_NUMBER);
            else note_err(E_UNCLOSED);
        end
        r.doc_valid = err_first == E_NONE;
        r.error_kind = err_first;
        r.error_offset = err_first == E_NONE ? 32'd0 : err_pos;
        doc_verdicts.push_back(r);
        clear_doc();
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_w.valid && out_w.ready) begin
            if (doc_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                want = doc_verdicts.pop_front();
                if (out_w.doc_valid !== want.doc_valid || out_w.error_kind !== want.error_kind
                    || out_w.error_offset !== want.error_offset) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp valid %0d kind %0d off %0d, got %0d %0d %0d",
                                 want.doc_valid, want.error_kind, want.error_offset,
                                 out_w.doc_valid, out_w.error_kind, out_w.error_offset);
                end
            end
        end
        if (i_rst_n && in_w.valid && in_w.ready) take_byte(in_w.text_byte, in_w.end_of_doc);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        out_w.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                out_w.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            out_w.ready <= !(rx_idle_on && $urandom_range(99) < 31);
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while (tx_idle_on && $urandom_range(99) < 31) begin
            in_w.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_w.valid <= 1'b1;
        in_w.text_byte <= b;
        in_w.end_of_doc <= last;
        do @(posedge i_clk); while (!(in_w.valid && in_w.ready));
        @(negedge i_clk);
    endtask

    task automatic send_doc(bytes_t q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic set_limit(int v);
        in_w.valid <= 1'b0;
        while (doc_verdicts.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[DL_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    function automatic void add_text(ref bytes_t q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void add_blank(ref bytes_t q);
        string blanks;
        blanks = " \t\n\r";
        if ($urandom_range(3) == 0) q.push_back(blanks[$urandom_range(3)]);
    endfunction

    function automatic void gen_string(ref bytes_t q);
        string esc;
        string hx;
        logic [7:0] c;
        esc = "\"\\/bfnrt";
        hx = "0123456789abcdefABCDEF";
        q.push_back("\"");
        repeat ($urandom_range(4)) begin
            case ($urandom_range(3))
                0: begin
                    q.push_back(8'h5c);
                    q.push_back(esc[$urandom_range(7)]);
                end
                1: begin
                    add_text(q, "\\u");
                    repeat (4) q.push_back(hx[$urandom_range(21)]);
                end
                default: begin
                    do c = $urandom_range(255); while (c == "\"" || c == 8'h5c);
                    q.push_back(c);
                end
            endcase
        end
        q.push_back("\"");
    endfunction

    function automatic void gen_digits(ref bytes_t q, input int n);
        repeat (n) q.push_back("0" + $urandom_range(9));
    endfunction

    function automatic void gen_number(ref bytes_t q);
        if ($urandom_range(1)) q.push_back("-");
        if ($urandom_range(2) == 0) q.push_back("0");
        else begin
            q.push_back("1" + $urandom_range(8));
            gen_digits(q, $urandom_range(3));
        end
        if ($urandom_range(1)) begin
            q.push_back(".");
            gen_digits(q, $urandom_range(1, 3));
        end
        if ($urandom_range(2) == 0) begin
            q.push_back($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0: q.push_back("+");
                1: q.push_back("-");
                default: ;
            endcase
            gen_digits(q, $urandom_range(1, 2));
        end
    endfunction

    function automatic void gen_container(ref bytes_t q, input int d);
        bit obj;
        int n;
        obj = $urandom_range(1);
        n = $urandom_range(3);
        q.push_back(obj ? "{" : "[");
        add_blank(q);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                q.push_back(",");
                add_blank(q);
            end
            if (obj) begin
                gen_string(q);
                add_blank(q);
                q.push_back(":");
                add_blank(q);
            end
            gen_value(q, d - 1);
            add_blank(q);
        end
        q.push_back(obj ? "}" : "]");
    endfunction

    function automatic void gen_value(ref bytes_t q, input int d);
        case ($urandom_range(d > 0 ? 7 : 5))
            0: add_text(q, "null");
            1: add_text(q, "true");
            2: add_text(q, "false");
            3: gen_string(q);
            4, 5: gen_number(q);
            default: gen_container(q, d);
        endcase
    endfunction

    function automatic bytes_t nested_doc(int n);
        bytes_t q;
        repeat (n) q.push_back($urandom_range(1) ? "[" : "[");
        if (n > 0) add_text(q, "1");
        repeat (n) q.push_back("]");
        if (n == 0) q.push_back(" ");
        return q;
    endfunction

    function automatic bytes_t random_doc();
        bytes_t q;
        int lim;
        lim = limit_reg < 64 ? limit_reg : 64;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) q.push_back($urandom_range(255));
            return q;
        end
        if ($urandom_range(19) == 0) begin
            q = nested_doc(lim + $urandom_range(1));
        end else begin
            repeat ($urandom_range(2)) begin
                add_blank(q);
                gen_container(q, $urandom_range(3));
                add_blank(q);
            end
        end
        if (q.size() == 0) q.push_back(" ");
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0: q[$urandom_range(q.size() - 1)] = $urandom_range(255);
                1: q = q[0:$urandom_range(q.size() - 1)];
                default: q.insert($urandom_range(q.size() - 1), $urandom_range(255));
            endcase
        end
        return q;
    endfunction

    doc_row_t doc_table[] = '{
        '{" ",                 1, E_NONE,     0},
        '{"x",                 1, E_TOP,      0},
        '{"{}",                1, E_NONE,     0},
        '{"[]",                1, E_NONE,     0},
        '{"{1",                1, E_NAME,     1},
        '{"{\"a\"1",           1, E_COLON,    4},
        '{"[}",                1, E_VALUE,    1},
        '{"{]",                1, E_NAME,     1},
        '{"[1}",               1, E_COMMA,    2},
        '{"[1,]",              1, E_VALUE,    3},
        '{"{\"a\":1,}",        1, E_NAME,     7},
        '{"[\"\\q\"]",         1, E_ESCAPE,   3},
        '{"[\"\\u12g4\"]",     1, E_ESCAPE,   6},
        '{"[\"ab",             1, E_STRING,   4},
        '{"[nul",              1, E_LITERAL,  4},
        '{"[nux]",             1, E_LITERAL,  3},
        '{"[01]",              1, E_NUMBER,   2},
        '{"[1.]",              1, E_NUMBER,   3},
        '{"[1e]",              1, E_NUMBER,   3},
        '{"[-",                1, E_NUMBER,   2},
        '{"[",                 1, E_UNCLOSED, 1},
        '{"[true,false,null,-0.5e+3,0E-1,\"\\u00aF\\n\"] {\"k\":{}}", 0, E_NONE, 0}
    };

    initial begin
        int limits[6];
        int sent;
        bytes_t q;
        t_result typed_res;
        mismatches = 0;
        quiet_cycles = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_req = 1'b0;
        limit_reg = 64;
        clear_doc();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_w.valid = 1'b0;
        in_w.text_byte = '0;
        in_w.end_of_doc = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (doc_table[r]) begin
            q = {};
            add_text(q, doc_table[r].text);
            send_doc(q);
            if (doc_table[r].typed) begin
                typed_res.doc_valid = doc_table[r].kind == E_NONE;
                typed_res.error_kind = doc_table[r].kind;
                typed_res.error_offset = doc_table[r].offset;
                doc_verdicts[$] = typed_res;
            end
        end

        limits = '{64, 1, 0, 127, 3, $urandom_range(2, 63)};
        foreach (limits[p]) begin
            set_limit(limits[p]);
            tx_idle_on = p != 1;
            rx_idle_on = p != 1;
            send_doc(nested_doc(limits[p] < 64 ? limits[p] : 64));
            send_doc(nested_doc((limits[p] < 64 ? limits[p] : 64) + 1));
            if (p == 2) begin
                // results back up while the sink holds off
                rx_hold_req = 1'b1;
                repeat (40) begin
                    q = {};
                    add_text(q, "[]");
                    send_doc(q);
                end
            end
            sent = 0;
            while (sent < 50) begin
                q = random_doc();
                send_doc(q);
                sent += q.size();
            end
        end

        in_w.valid <= 1'b0;
        while (doc_verdicts.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### json_syntax_validator_top.f
hdl/jsv_pkg.sv
hdl/jsv_if.sv
hdl/json_syntax_validator_top.sv
tb/json_syntax_validator_top_tb.sv
